/* rtl/mmsl_pkg.sv */
package mmsl_pkg;

    localparam int W      = 32;            // data word
    localparam int F      = 16;            // fraction bits
    localparam int IDXW   = 16;            // element index
    localparam int DIV_NB = W + F + 2;     // dividend magnitude bits
    localparam int SATW   = 2 * W + 4;     // headroom for saturation
    localparam int HSW    = 2 * W - F;     // half-step width

    typedef logic signed [W-1:0] t_word;

    localparam t_word WMAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word WMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [1:0] CFG_TOL = 2'd0;
    localparam logic [1:0] CFG_WDE = 2'd1;
    localparam logic [1:0] CFG_THR = 2'd2;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DIV_NB-1:0] num;
        logic [W-1:0]      den;
    } t_div_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word quot;
    } t_div_rsp;

    typedef struct packed {
        logic           start;
        logic [2*W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [W-1:0] root;
    } t_sqrt_rsp;

    function automatic t_word sat_w(input logic signed [SATW-1:0] v);
        t_word r;
        if (v > SATW'(WMAX)) begin
            r = WMAX;
        end else if (v < SATW'(WMIN)) begin
            r = WMIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic t_word sub_sat(input t_word a, input t_word b);
        logic signed [W:0] d;
        d = $signed({a[W-1], a}) - $signed({b[W-1], b});
        return sat_w(SATW'(d));
    endfunction

    function automatic t_word add_sat(input t_word a, input t_word b);
        logic signed [W:0] s;
        s = $signed({a[W-1], a}) + $signed({b[W-1], b});
        return sat_w(SATW'(s));
    endfunction

    // floor of the mean, arithmetic shift
    function automatic t_word avg_floor(input t_word a, input t_word b);
        logic signed [W:0] s;
        s = $signed({a[W-1], a}) + $signed({b[W-1], b});
        s = s >>> 1;
        return s[W-1:0];
    endfunction

    function automatic t_word minmod(input t_word a, input t_word b);
        t_word r;
        if (a > 0 && b > 0) begin
            r = (a < b) ? a : b;
        end else if (a < 0 && b < 0) begin
            r = (a > b) ? a : b;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic over_tol(input t_word a, input t_word b,
                                      input logic [15:0] tol);
        logic signed [W:0] d;
        logic [W:0]        m;
        d = $signed({a[W-1], a}) - $signed({b[W-1], b});
        m = d[W] ? (W+1)'(-d) : (W+1)'(d);
        return m > (W+1)'(tol);
    endfunction

endpackage

/* rtl/mmsl_ifs.sv */
interface mmsl_node_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic [30:0]       node_width;
    logic signed [31:0] node_bed;
    logic signed [31:0] area_left;
    logic signed [31:0] area_right;
    logic signed [31:0] flow_left;
    logic signed [31:0] flow_right;
    logic              first_node;
    logic              last_node;

    modport source (output valid, node_x, node_y, node_width, node_bed, area_left,
                    area_right, flow_left, flow_right, first_node, last_node,
                    input ready);
    modport sink (input valid, node_x, node_y, node_width, node_bed, area_left,
                  area_right, flow_left, flow_right, first_node, last_node,
                  output ready);
endinterface

interface mmsl_elem_if;
    logic              valid;
    logic              ready;
    logic [15:0]       element_index;
    logic signed [31:0] new_area_left;
    logic signed [31:0] new_area_right;
    logic signed [31:0] new_flow_left;
    logic signed [31:0] new_flow_right;
    logic              last_element;

    modport source (output valid, element_index, new_area_left, new_area_right,
                    new_flow_left, new_flow_right, last_element, input ready);
    modport sink (input valid, element_index, new_area_left, new_area_right,
                  new_flow_left, new_flow_right, last_element, output ready);
endinterface

interface mmsl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mmsl_div.sv */
module mmsl_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmsl_pkg::t_div_req  i_req,
    output mmsl_pkg::t_div_rsp  o_rsp
);
    import mmsl_pkg::*;

    localparam int CW = $clog2(DIV_NB);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_NB-1:0] r_num;
    logic [DIV_NB-1:0] r_quo;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_den;
    logic              r_neg;
    logic              r_dz;

    logic [W:0]        rem_sh;
    logic              fits;
    t_word             quot;

    assign rem_sh = {r_rem, r_num[DIV_NB-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_comb begin
        if (r_dz) begin
            quot = '0;
        end else if (r_neg) begin
            quot = (r_quo >= DIV_NB'({1'b0, WMIN})) ? WMIN : t_word'(-r_quo[W-1:0]);
        end else begin
            quot = (r_quo > DIV_NB'(WMAX)) ? WMAX : t_word'(r_quo[W-1:0]);
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quot: quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
                r_dz   <= (i_req.den == '0);
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                // one quotient bit a cycle, restoring
                r_num <= {r_num[DIV_NB-2:0], 1'b0};
                r_quo <= {r_quo[DIV_NB-2:0], fits};
                r_rem <= fits ? W'(rem_sh - {1'b0, r_den}) : rem_sh[W-1:0];
                if (r_cnt == CW'(DIV_NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

endmodule

/* rtl/mmsl_sqrt.sv */
module mmsl_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmsl_pkg::t_sqrt_req i_req,
    output mmsl_pkg::t_sqrt_rsp o_rsp
);
    import mmsl_pkg::*;

    localparam int CW = $clog2(W);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [2*W-1:0] r_rad;
    logic [W+2:0]   r_rem;
    logic [W-1:0]   r_root;

    logic [W+4:0]   rem_sh;
    logic [W+4:0]   trial;
    logic           fits;

    assign rem_sh = {r_rem[W+2:0], r_rad[2*W-1:2*W-2]};
    assign trial  = {3'b000, r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    assign o_rsp = '{busy: r_busy, done: r_done, root: r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_req.rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                // one root bit a cycle from each bit pair
                r_rad  <= {r_rad[2*W-3:0], 2'b00};
                r_rem  <= fits ? (W+3)'(rem_sh - trial) : rem_sh[W+2:0];
                r_root <= {r_root[W-2:0], fits};
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("root done without a run");

endmodule

/* rtl/minmod_slope_limiter_1d_unit.sv */
// Minmod slope limiter for a 1-D channel, one mesh node per beat.
// i_node carries a node (coordinates, width, bed) and the area/discharge pair
// of the element that ends at it; first_node opens a channel, last_node ends
// it. o_elem returns one beat per element, one element late: a node that
// closes an interior element releases the one before it, and the last node
// also releases its own element. i_cfg writes change_tolerance (0),
// wet_dry_enable (1) and dry_depth_threshold (2); write only while idle.
// A node is worked on alone; i_node.ready is low until it is finished.
// Work runs through the shared restoring divider and root unit: a first node
// that closes no open channel needs no division, a node that closes an element
// without a report takes two divisions and one root, and one that also reports
// an element takes up to six divisions, one root, and the product steps; a last
// node adds one more report.
// A finished beat waits in the output register while the next node is taken;
// a stalled receiver holds the block only at the point where the next beat
// must load. Reset empties the channel window and restores the register
// defaults (tolerance 1, limiting everywhere, threshold 0).
module minmod_slope_limiter_1d_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mmsl_node_if.sink         i_node,
    mmsl_elem_if.source       o_elem,
    mmsl_cfg_if.sink          i_cfg
);
    import mmsl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_H0, S_H0W, S_H1, S_H1W, S_LEN, S_LEN2, S_LEN3, S_LENW,
        S_AVG, S_BR, S_EMIT0, S_SL, S_SLW, S_MM, S_HS1, S_HS2, S_LIM, S_SEL,
        S_NH, S_NA0, S_NA1, S_NA2, S_OUT, S_AFTER
    } t_state;

    typedef enum logic [1:0] {A_FIRST, A_MID, A_END} t_after;

    t_state r_state;
    t_after r_after;

    // configuration
    logic [15:0]  r_tol;
    logic         r_wde;
    logic [W-2:0] r_thr;

    // node being worked on
    t_word        r_cx, r_cy, r_cb, r_ca0, r_ca1, r_cq0, r_cq1;
    logic [W-2:0] r_cw;
    logic         r_cfirst, r_clast;

    // previous node
    t_word        r_px, r_py, r_pb;
    logic [W-2:0] r_pw;

    // pending element
    t_word        r_pa0, r_pa1, r_pq0, r_pq1, r_pz0, r_pz1, r_ph0, r_ph1, r_paq, r_pdh;
    logic [W-2:0] r_pw0, r_pw1;

    // new element, and the one behind the pending one
    t_word        r_eh0, r_eh1, r_eaq, r_edh, r_ez;
    t_word        r_bz, r_bq, r_bd;

    logic [IDXW-1:0] r_es;
    logic [1:0]      r_wv;

    // report sequence
    logic                   r_has_nxt, r_elast;
    logic [1:0]             r_k;
    t_word                  r_sl [4];
    t_word                  r_zt0, r_zt1, r_az, r_s1, r_s2;
    logic signed [HSW-1:0]  r_hs1, r_hs2;
    t_word                  r_zf0, r_zf1, r_qf0, r_qf1, r_nh0, r_nh1, r_na0, r_na1;
    logic [IDXW-1:0]        r_oidx;
    logic signed [2*W+1:0]  r_prod;
    logic [2*W-1:0]         r_sq0;

    // output register
    logic            r_out_valid;
    logic [IDXW-1:0] r_o_idx;
    t_word           r_o_a0, r_o_a1, r_o_q0, r_o_q1;
    logic            r_o_last;

    // shared units
    t_div_req  r_div;
    t_div_rsp  div_rsp;
    t_sqrt_req r_sq;
    t_sqrt_rsp sq_rsp;

    mmsl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_div), .o_rsp(div_rsp));
    mmsl_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_sq), .o_rsp(sq_rsp));

    // node distance
    logic signed [W:0] ddx, ddy, adx, ady;
    logic              far;

    assign ddx = $signed({r_cx[W-1], r_cx}) - $signed({r_px[W-1], r_px});
    assign ddy = $signed({r_cy[W-1], r_cy}) - $signed({r_py[W-1], r_py});
    assign adx = ddx[W] ? -ddx : ddx;
    assign ady = ddy[W] ? -ddy : ddy;
    assign far = (adx > $signed({1'b0, WMAX})) || (ady > $signed({1'b0, WMAX}));

    // shared multiplier, product registered
    logic signed [W:0]     mul_a, mul_b;
    logic signed [2*W+1:0] mul_p;

    always_comb begin
        case (r_state)
            S_LEN:   begin mul_a = adx;                          mul_b = adx; end
            S_LEN2:  begin mul_a = ady;                          mul_b = ady; end
            S_HS1:   begin mul_a = $signed({r_s1[W-1], r_s1});   mul_b = $signed({1'b0, r_pdh}); end
            S_HS2:   begin mul_a = $signed({r_s2[W-1], r_s2});   mul_b = $signed({1'b0, r_pdh}); end
            S_NA0:   begin mul_a = $signed({r_nh0[W-1], r_nh0}); mul_b = $signed({2'b00, r_pw0}); end
            S_NA1:   begin mul_a = $signed({r_nh1[W-1], r_nh1}); mul_b = $signed({2'b00, r_pw1}); end
            default: begin mul_a = '0;                           mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product divided by a power of two, toward zero
    logic signed [2*W+1:0] p_hs, p_na;
    assign p_hs = (r_prod < 0) ? (r_prod + (2*W+2)'((1 << (F + 1)) - 1)) >>> (F + 1)
                               : r_prod >>> (F + 1);
    assign p_na = (r_prod < 0) ? (r_prod + (2*W+2)'((1 << F) - 1)) >>> F
                               : r_prod >>> F;

    // depth division operands
    logic [W-1:0] amag0, amag1;
    assign amag0 = r_ca0[W-1] ? W'(-r_ca0) : W'(r_ca0);
    assign amag1 = r_ca1[W-1] ? W'(-r_ca1) : W'(r_ca1);

    // slope division operands
    logic signed [W:0] sdiff;
    logic [W:0]        sdmag;
    logic [W-1:0]      slen;
    t_word             sother;
    logic              sen;

    always_comb begin
        case (r_k)
            2'd0: begin
                sdiff  = $signed({r_az[W-1], r_az}) - $signed({r_bz[W-1], r_bz});
                sother = r_bd;
                sen    = (r_wv == 2'd3);
            end
            2'd1: begin
                sdiff  = $signed({r_paq[W-1], r_paq}) - $signed({r_bq[W-1], r_bq});
                sother = r_bd;
                sen    = (r_wv == 2'd3);
            end
            2'd2: begin
                sdiff  = $signed({r_ez[W-1], r_ez}) - $signed({r_az[W-1], r_az});
                sother = r_edh;
                sen    = r_has_nxt;
            end
            default: begin
                sdiff  = $signed({r_eaq[W-1], r_eaq}) - $signed({r_paq[W-1], r_paq});
                sother = r_edh;
                sen    = r_has_nxt;
            end
        endcase
        sdmag = sdiff[W] ? (W+1)'(-sdiff) : (W+1)'(sdiff);
        slen  = W'(r_pdh) + W'(sother);
    end

    // limited ends and the change test
    t_word l0, l1, m0, m1;
    logic  chg_z, chg_q, modify;

    always_comb begin
        l0 = sat_w(SATW'(r_az) - SATW'(r_hs1));
        l1 = sat_w(SATW'(r_az) + SATW'(r_hs1));
        m0 = sat_w(SATW'(r_paq) - SATW'(r_hs2));
        m1 = sat_w(SATW'(r_paq) + SATW'(r_hs2));
        chg_z = over_tol(l0, r_zt0, r_tol) || over_tol(l1, r_zt1, r_tol);
        chg_q = over_tol(m0, r_pq0, r_tol) || over_tol(m1, r_pq1, r_tol);
        modify = !r_wde || (r_ph0 > $signed({1'b0, r_thr}) && r_ph1 > $signed({1'b0, r_thr})
                            && r_nh0 > 0 && r_nh1 > 0);
    end

    assign i_node.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_elem.valid          = r_out_valid;
    assign o_elem.element_index  = r_o_idx;
    assign o_elem.new_area_left  = r_o_a0;
    assign o_elem.new_area_right = r_o_a1;
    assign o_elem.new_flow_left  = r_o_q0;
    assign o_elem.new_flow_right = r_o_q1;
    assign o_elem.last_element   = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= A_FIRST;
            r_tol       <= 16'd1;
            r_wde       <= 1'b0;
            r_thr       <= '0;
            r_es        <= '0;
            r_wv        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_div.start <= 1'b0;
            r_sq.start  <= 1'b0;
        end else begin
            r_div.start <= 1'b0;
            r_sq.start  <= 1'b0;
            r_prod      <= mul_p;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_TOL: r_tol <= i_cfg.data[15:0];
                    CFG_WDE: r_wde <= i_cfg.data[0];
                    CFG_THR: r_thr <= i_cfg.data;
                    default: ;
                endcase
            end

            // the load step refills the register itself
            if (o_elem.valid && o_elem.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_node.valid) begin
                        r_cx     <= i_node.node_x;
                        r_cy     <= i_node.node_y;
                        r_cw     <= i_node.node_width;
                        r_cb     <= i_node.node_bed;
                        r_ca0    <= i_node.area_left;
                        r_ca1    <= i_node.area_right;
                        r_cq0    <= i_node.flow_left;
                        r_cq1    <= i_node.flow_right;
                        r_cfirst <= i_node.first_node;
                        r_clast  <= i_node.last_node;
                        r_state  <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (r_cfirst || r_wv == 2'd0) begin
                        r_after <= A_FIRST;
                        if (r_wv[1]) begin
                            // close the open channel first
                            r_has_nxt <= 1'b0;
                            r_elast   <= 1'b1;
                            r_state   <= S_EMIT0;
                        end else begin
                            r_state <= S_AFTER;
                        end
                    end else begin
                        r_state <= S_H0;
                    end
                end
                S_H0: begin
                    r_div.start <= 1'b1;
                    r_div.neg   <= r_ca0[W-1];
                    r_div.num   <= DIV_NB'(amag0) << F;
                    r_div.den   <= {1'b0, r_pw};
                    r_state     <= S_H0W;
                end
                S_H0W: begin
                    if (div_rsp.done) begin
                        r_eh0   <= div_rsp.quot;
                        r_state <= S_H1;
                    end
                end
                S_H1: begin
                    r_div.start <= 1'b1;
                    r_div.neg   <= r_ca1[W-1];
                    r_div.num   <= DIV_NB'(amag1) << F;
                    r_div.den   <= {1'b0, r_cw};
                    r_state     <= S_H1W;
                end
                S_H1W: begin
                    if (div_rsp.done) begin
                        r_eh1   <= div_rsp.quot;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (far) begin
                        r_edh   <= WMAX;
                        r_state <= S_AVG;
                    end else begin
                        r_state <= S_LEN2;
                    end
                end
                S_LEN2: begin
                    r_sq0   <= r_prod[2*W-1:0];
                    r_state <= S_LEN3;
                end
                S_LEN3: begin
                    r_sq.start <= 1'b1;
                    r_sq.rad   <= r_sq0 + r_prod[2*W-1:0];
                    r_state    <= S_LENW;
                end
                S_LENW: begin
                    if (sq_rsp.done) begin
                        r_edh   <= sq_rsp.root[W-1] ? WMAX : t_word'(sq_rsp.root);
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_eaq   <= avg_floor(r_cq0, r_cq1);
                    r_ez    <= avg_floor(sub_sat(r_eh0, r_pb), sub_sat(r_eh1, r_cb));
                    r_state <= S_BR;
                end
                S_BR: begin
                    if (r_wv[1]) begin
                        r_has_nxt <= 1'b1;
                        r_elast   <= 1'b0;
                        r_after   <= A_MID;
                        r_state   <= S_EMIT0;
                    end else begin
                        // first element of the channel: hold it pending
                        r_pa0 <= r_ca0; r_pa1 <= r_ca1; r_pq0 <= r_cq0; r_pq1 <= r_cq1;
                        r_pw0 <= r_pw;  r_pw1 <= r_cw;  r_pz0 <= r_pb;  r_pz1 <= r_cb;
                        r_ph0 <= r_eh0; r_ph1 <= r_eh1; r_paq <= r_eaq; r_pdh <= r_edh;
                        r_es  <= r_es + 1'b1;
                        r_px  <= r_cx;  r_py  <= r_cy;  r_pw  <= r_cw;  r_pb  <= r_cb;
                        r_wv  <= 2'd2;
                        if (r_clast) begin
                            r_has_nxt <= 1'b0;
                            r_elast   <= 1'b1;
                            r_after   <= A_END;
                            r_state   <= S_EMIT0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT0: begin
                    r_zt0   <= sub_sat(r_ph0, r_pz0);
                    r_zt1   <= sub_sat(r_ph1, r_pz1);
                    r_az    <= avg_floor(sub_sat(r_ph0, r_pz0), sub_sat(r_ph1, r_pz1));
                    r_oidx  <= r_es - 1'b1;
                    r_k     <= '0;
                    r_state <= S_SL;
                end
                S_SL: begin
                    if (sen && slen != '0) begin
                        r_div.start <= 1'b1;
                        r_div.neg   <= sdiff[W];
                        r_div.num   <= DIV_NB'(sdmag) << (F + 1);
                        r_div.den   <= slen;
                        r_state     <= S_SLW;
                    end else begin
                        r_sl[r_k] <= '0;
                        r_k       <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            r_state <= S_MM;
                        end
                    end
                end
                S_SLW: begin
                    if (div_rsp.done) begin
                        r_sl[r_k] <= div_rsp.quot;
                        r_k       <= r_k + 1'b1;
                        r_state   <= (r_k == 2'd3) ? S_MM : S_SL;
                    end
                end
                S_MM: begin
                    r_s1    <= minmod(r_sl[0], r_sl[2]);
                    r_s2    <= minmod(r_sl[1], r_sl[3]);
                    r_state <= S_HS1;
                end
                S_HS1: r_state <= S_HS2;
                S_HS2: begin
                    r_hs1   <= p_hs[HSW-1:0];
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_hs2   <= p_hs[HSW-1:0];
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_zf0   <= chg_z ? l0 : r_zt0;
                    r_zf1   <= chg_z ? l1 : r_zt1;
                    r_qf0   <= chg_q ? m0 : r_pq0;
                    r_qf1   <= chg_q ? m1 : r_pq1;
                    r_state <= S_NH;
                end
                S_NH: begin
                    r_nh0   <= add_sat(r_zf0, r_pz0);
                    r_nh1   <= add_sat(r_zf1, r_pz1);
                    r_state <= S_NA0;
                end
                S_NA0: r_state <= S_NA1;
                S_NA1: begin
                    r_na0   <= sat_w(SATW'(p_na));
                    r_state <= S_NA2;
                end
                S_NA2: begin
                    r_na1   <= sat_w(SATW'(p_na));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_elem.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_idx     <= r_oidx;
                        r_o_a0      <= modify ? r_na0 : r_pa0;
                        r_o_a1      <= modify ? r_na1 : r_pa1;
                        r_o_q0      <= modify ? r_qf0 : r_pq0;
                        r_o_q1      <= modify ? r_qf1 : r_pq1;
                        r_o_last    <= r_elast;
                        r_state     <= S_AFTER;
                    end
                end
                S_AFTER: begin
                    case (r_after)
                        A_FIRST: begin
                            r_px    <= r_cx; r_py <= r_cy; r_pw <= r_cw; r_pb <= r_cb;
                            r_es    <= '0;
                            r_wv    <= r_clast ? 2'd0 : 2'd1;
                            r_state <= S_IDLE;
                        end
                        A_MID: begin
                            r_bz  <= r_az; r_bq <= r_paq; r_bd <= r_pdh;
                            r_wv  <= 2'd3;
                            r_pa0 <= r_ca0; r_pa1 <= r_ca1; r_pq0 <= r_cq0; r_pq1 <= r_cq1;
                            r_pw0 <= r_pw;  r_pw1 <= r_cw;  r_pz0 <= r_pb;  r_pz1 <= r_cb;
                            r_ph0 <= r_eh0; r_ph1 <= r_eh1; r_paq <= r_eaq; r_pdh <= r_edh;
                            r_es  <= r_es + 1'b1;
                            r_px  <= r_cx;  r_py  <= r_cy;  r_pw  <= r_cw;  r_pb  <= r_cb;
                            if (r_clast) begin
                                r_has_nxt <= 1'b0;
                                r_elast   <= 1'b1;
                                r_after   <= A_END;
                                r_state   <= S_EMIT0;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_wv    <= '0;
                            r_es    <= '0;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wv == 2'd0) |-> (r_es == '0))
        else $error("element count left over with no channel open");

    a_beat_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output beat loaded outside the load step");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_node.valid && i_node.ready) |=> (r_state == S_DISP))
        else $error("accepted node not dispatched");

endmodule

/* test/minmod_slope_limiter_1d_unit_tb.sv */
module minmod_slope_limiter_1d_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mmsl_pkg::*;

    localparam longint ONE_Q = 64'sd65536;
    localparam longint WMAX_L = 64'sd2147483647;
    localparam longint WMIN_L = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        logic signed [31:0] x, y;
        logic [30:0]        w;
        logic signed [31:0] bed, al, ar, fl, fr;
        bit                 first, last;
    } t_node;

    typedef struct {
        logic [15:0]        idx;
        logic signed [31:0] al, ar, fl, fr;
        bit                 last;
    } t_elem;

    // element held while waiting for its right neighbour
    typedef struct {
        longint a0, a1, q0, q1, w0, w1, b0, b1, h0, h1, aq, len;
    } t_span;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic fail = 1'b0;
    int   cyc = 0;
    int   send_idle = 30;
    int   recv_idle = 70;

    mmsl_node_if node_ch ();
    mmsl_elem_if elem_ch ();
    mmsl_cfg_if  cfg_ch ();

    minmod_slope_limiter_1d_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_node  (node_ch.sink),
        .o_elem  (elem_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #10 i_clk = ~i_clk;

    t_node pending_nodes[$];
    t_elem expected_elems[$];

    // limiter state mirror
    longint tol_r = 1;
    bit     wet_only_r = 0;
    longint dry_thr_r = 0;
    longint prev_x, prev_y, prev_w, prev_bed;
    t_span  held;
    longint behind_z, behind_q, behind_len;
    int     elem_count;
    int     window;

    function automatic longint sat32(longint v);
        if (v > WMAX_L) return WMAX_L;
        if (v < WMIN_L) return WMIN_L;
        return v;
    endfunction

    function automatic longint div_trunc(longint n, longint d);
        if (d == 0) return 0;
        return sat32(n / d);
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint grad(longint diff, longint lsum);
        return div_trunc(diff * 2 * ONE_Q, lsum);
    endfunction

    function automatic longint minmod_l(longint a, longint b);
        if (a > 0 && b > 0) return a < b ? a : b;
        if (a < 0 && b < 0) return a > b ? a : b;
        return 0;
    endfunction

    function automatic longint level_mean(t_span s);
        return sat32((sat32(s.h0 - s.b0) + sat32(s.h1 - s.b1)) >>> 1);
    endfunction

    task automatic report_held(bit has_next, longint nz, longint nq, longint nlen,
                               bit is_last);
        longint zt0, zt1, az, a1, a2, b1, b2, s1, s2, hs1, hs2;
        longint l0, l1, m0, m1, zf0, zf1, qf0, qf1, nh0, nh1;
        bit     apply;
        t_elem  e;
        zt0 = sat32(held.h0 - held.b0);
        zt1 = sat32(held.h1 - held.b1);
        az = sat32((zt0 + zt1) >>> 1);
        a1 = 0; a2 = 0; b1 = 0; b2 = 0;
        if (window == 3) begin
            a1 = grad(az - behind_z, held.len + behind_len);
            a2 = grad(held.aq - behind_q, held.len + behind_len);
        end
        if (has_next) begin
            b1 = grad(nz - az, held.len + nlen);
            b2 = grad(nq - held.aq, held.len + nlen);
        end
        s1 = minmod_l(a1, b1);
        s2 = minmod_l(a2, b2);
        hs1 = (s1 * held.len) / (2 * ONE_Q);
        hs2 = (s2 * held.len) / (2 * ONE_Q);
        l0 = sat32(az - hs1);
        l1 = sat32(az + hs1);
        m0 = sat32(held.aq - hs2);
        m1 = sat32(held.aq + hs2);
        zf0 = zt0; zf1 = zt1;
        if (abs_l(l0 - zt0) > tol_r || abs_l(l1 - zt1) > tol_r) begin
            zf0 = l0; zf1 = l1;
        end
        qf0 = held.q0; qf1 = held.q1;
        if (abs_l(m0 - held.q0) > tol_r || abs_l(m1 - held.q1) > tol_r) begin
            qf0 = m0; qf1 = m1;
        end
        nh0 = sat32(zf0 + held.b0);
        nh1 = sat32(zf1 + held.b1);
        apply = 1'b1;
        if (wet_only_r)
            apply = held.h0 > dry_thr_r && held.h1 > dry_thr_r && nh0 > 0 && nh1 > 0;
        e.idx = 16'(elem_count - 1);
        if (apply) begin
            e.al = 32'(sat32((nh0 * held.w0) / ONE_Q));
            e.ar = 32'(sat32((nh1 * held.w1) / ONE_Q));
            e.fl = 32'(qf0);
            e.fr = 32'(qf1);
        end else begin
            e.al = 32'(held.a0);
            e.ar = 32'(held.a1);
            e.fl = 32'(held.q0);
            e.fr = 32'(held.q1);
        end
        e.last = is_last;
        expected_elems.push_back(e);
    endtask

    task automatic predict_node(t_node n);
        longint cx, cy, cw, cb, dx, dy;
        longint unsigned rad;
        t_span  el;
        cx = n.x; cy = n.y; cw = {33'd0, n.w}; cb = n.bed;
        if (n.first || window == 0) begin
            if (window >= 2) report_held(0, 0, 0, 0, 1);
            prev_x = cx; prev_y = cy; prev_w = cw; prev_bed = cb;
            elem_count = 0;
            window = n.last ? 0 : 1;
            return;
        end
        el.a0 = n.al; el.a1 = n.ar; el.q0 = n.fl; el.q1 = n.fr;
        el.w0 = prev_w; el.w1 = cw;
        el.b0 = prev_bed; el.b1 = cb;
        el.h0 = div_trunc(el.a0 * ONE_Q, el.w0);
        el.h1 = div_trunc(el.a1 * ONE_Q, el.w1);
        el.aq = sat32((el.q0 + el.q1) >>> 1);
        dx = abs_l(cx - prev_x);
        dy = abs_l(cy - prev_y);
        if (dx > WMAX_L || dy > WMAX_L) begin
            el.len = WMAX_L;
        end else begin
            rad = dx * dx + dy * dy;
            el.len = sat32(longint'(root_floor(rad)));
        end
        if (window >= 2) begin
            report_held(1, level_mean(el), el.aq, el.len, 0);
            behind_z = level_mean(held);
            behind_q = held.aq;
            behind_len = held.len;
            window = 3;
        end else begin
            window = 2;
        end
        held = el;
        elem_count = (elem_count + 1) & 16'hFFFF;
        prev_x = cx; prev_y = cy; prev_w = cw; prev_bed = cb;
        if (n.last) begin
            report_held(0, 0, 0, 0, 1);
            window = 0;
            elem_count = 0;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_ch.valid <= 1'b0;
        end else if (!node_ch.valid || node_ch.ready) begin
            if (pending_nodes.size() > 0 && $urandom_range(99) >= send_idle) begin
                t_node n;
                n = pending_nodes.pop_front();
                node_ch.valid      <= 1'b1;
                node_ch.node_x     <= n.x;
                node_ch.node_y     <= n.y;
                node_ch.node_width <= n.w;
                node_ch.node_bed   <= n.bed;
                node_ch.area_left  <= n.al;
                node_ch.area_right <= n.ar;
                node_ch.flow_left  <= n.fl;
                node_ch.flow_right <= n.fr;
                node_ch.first_node <= n.first;
                node_ch.last_node  <= n.last;
            end else begin
                node_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) elem_ch.ready <= 1'b0;
        else elem_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // predict on each accepted node beat, check each result beat
    always @(posedge i_clk) begin
        if (i_rst_n && node_ch.valid && node_ch.ready) begin
            t_node n;
            n.x = node_ch.node_x; n.y = node_ch.node_y; n.w = node_ch.node_width;
            n.bed = node_ch.node_bed;
            n.al = node_ch.area_left; n.ar = node_ch.area_right;
            n.fl = node_ch.flow_left; n.fr = node_ch.flow_right;
            n.first = node_ch.first_node; n.last = node_ch.last_node;
            predict_node(n);
        end
        if (i_rst_n && elem_ch.valid && elem_ch.ready) begin
            if (expected_elems.size() == 0) begin
                $error("unexpected element beat, index %0d", elem_ch.element_index);
                fail = 1'b1;
            end else begin
                t_elem e;
                e = expected_elems.pop_front();
                if (elem_ch.element_index !== e.idx) begin
                    $error("element_index exp %0d got %0d", e.idx, elem_ch.element_index);
                    fail = 1'b1;
                end
                if (elem_ch.new_area_left !== e.al) begin
                    $error("new_area_left exp %h got %h", e.al, elem_ch.new_area_left);
                    fail = 1'b1;
                end
                if (elem_ch.new_area_right !== e.ar) begin
                    $error("new_area_right exp %h got %h", e.ar, elem_ch.new_area_right);
                    fail = 1'b1;
                end
                if (elem_ch.new_flow_left !== e.fl) begin
                    $error("new_flow_left exp %h got %h", e.fl, elem_ch.new_flow_left);
                    fail = 1'b1;
                end
                if (elem_ch.new_flow_right !== e.fr) begin
                    $error("new_flow_right exp %h got %h", e.fr, elem_ch.new_flow_right);
                    fail = 1'b1;
                end
                if (elem_ch.last_element !== e.last) begin
                    $error("last_element exp %0d got %0d", e.last, elem_ch.last_element);
                    fail = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus generation
    int     gen_mode = 0;   // 0 normal, 1 extremes, 2 zero width, 3 repeated point
    longint walk_x = 0, walk_y = 0;

    function automatic logic [31:0] pick_word(longint span);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            2:       return ($urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF);
            default: return 32'($signed(longint'($urandom_range(2 * span))) - span);
        endcase
    endfunction

    function automatic t_node make_node(bit first, bit last);
        t_node n;
        n.first = first;
        n.last = last;
        if (gen_mode == 1) begin
            n.x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            n.y = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            n.w = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd1;
            n.bed = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            n.al = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            n.ar = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            n.fl = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            n.fr = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            return n;
        end
        if (gen_mode != 3) begin
            walk_x = walk_x + $urandom_range(32'h40000);
            walk_y = walk_y + $urandom_range(32'h8000) - 32'h4000;
        end
        n.x = ($urandom_range(19) == 0) ? 32'($urandom) : 32'(walk_x);
        n.y = ($urandom_range(19) == 0) ? 32'($urandom) : 32'(walk_y);
        if (gen_mode == 2) n.w = '0;
        else if ($urandom_range(9) == 0) n.w = 31'($urandom);
        else n.w = 31'($urandom_range(32'h8000, 32'h100000));
        n.bed = pick_word(32'h30000);
        n.al = ($urandom_range(3) == 0) ? pick_word(32'h100000)
                                        : 32'($urandom_range(32'h300000));
        n.ar = ($urandom_range(3) == 0) ? pick_word(32'h100000)
                                        : 32'($urandom_range(32'h300000));
        n.fl = pick_word(32'h80000);
        n.fr = pick_word(32'h80000);
        return n;
    endfunction

    task automatic add_channel(int nodes, bit mark_first, bit mark_last);
        for (int k = 0; k < nodes; k++)
            pending_nodes.push_back(make_node(mark_first && k == 0,
                                              mark_last && k == nodes - 1));
    endtask

    task automatic add_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            int len, r;
            len = $urandom_range(2, 9);
            r = $urandom_range(19);
            if (r == 0) begin
                pending_nodes.push_back(make_node($urandom_range(1), $urandom_range(1)));
                len = 1;
            end else if (r == 1) begin
                add_channel(len, 1, 0);         // broken: no closing node
            end else if (r == 2) begin
                add_channel(len, 0, 1);         // opened without a first mark
            end else begin
                add_channel(len, 1, 1);
            end
            sent += len;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_TOL: tol_r = val[15:0];
            CFG_WDE: wet_only_r = val[0];
            CFG_THR: dry_thr_r = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_nodes.size() > 0 || node_ch.valid || expected_elems.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        node_ch.valid = 1'b0;
        node_ch.node_x = '0; node_ch.node_y = '0; node_ch.node_width = '0;
        node_ch.node_bed = '0; node_ch.area_left = '0; node_ch.area_right = '0;
        node_ch.flow_left = '0; node_ch.flow_right = '0;
        node_ch.first_node = 1'b0; node_ch.last_node = 1'b0;
        elem_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = CFG_TOL; cfg_ch.data = '0;
        window = 0;
        elem_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes, zero width, repeated point, framing cases
        add_channel(4, 1, 1);
        gen_mode = 1; add_channel(4, 1, 1);
        gen_mode = 2; add_channel(3, 1, 1);
        gen_mode = 3; add_channel(3, 1, 1);
        gen_mode = 0;
        add_channel(1, 1, 1);               // first and last together
        add_channel(3, 0, 1);               // node while idle opens a channel
        add_channel(3, 1, 0);               // left open, next first closes it
        add_channel(3, 1, 1);
        add_random(110);
        drain();

        write_reg(CFG_TOL, 31'd0);
        write_reg(CFG_WDE, 31'd0);
        write_reg(CFG_THR, 31'd0);
        add_random(130);
        drain();

        send_idle = 70; recv_idle = 30;
        write_reg(CFG_TOL, 31'd65535);
        write_reg(CFG_WDE, 31'd1);
        add_random(130);
        drain();

        write_reg(CFG_TOL, 31'd0);
        write_reg(CFG_THR, 31'h7FFF_FFFF);
        add_random(130);
        drain();

        send_idle = 0; recv_idle = 0;
        write_reg(CFG_TOL, 31'd3);
        write_reg(CFG_THR, 31'($urandom_range(32'h20000)));
        add_random(130);
        drain();

        write_reg(CFG_TOL, 31'd1);
        write_reg(CFG_WDE, 31'd0);
        write_reg(CFG_THR, 31'd0);
        add_random(130);
        drain();

        if (!fail) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mmsl_pkg.sv
rtl/mmsl_ifs.sv
rtl/mmsl_div.sv
rtl/mmsl_sqrt.sv
rtl/minmod_slope_limiter_1d_unit.sv
test/minmod_slope_limiter_1d_unit_tb.sv
